/* rtl/mps_pkg.sv */
// Package with shared types, constants and status codes for the power sequence block.
`default_nettype none
package mps_pkg;
	localparam int WORD_BITS_DEF   = 64;
	localparam int LENGTH_BITS_DEF = 32;
	localparam int MOD_BITS        = 63;
	localparam int IDX_BITS        = 32;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_PAST_END = 2'd1,
		ST_BAD_BASE = 2'd2
	} status_t;

	typedef enum logic {
		ACT_START = 1'b0,
		ACT_NEXT  = 1'b1
	} action_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_MUL,
		S_RED,
		S_QUO,
		S_OUT
	} state_t;

	typedef enum logic [1:0] {
		OP_MULMOD,
		OP_QUO
	} op_t;

	// Control from the sequencer to the modular unit.
	typedef struct packed {
		logic start;
		op_t  op;
	} unit_ctl_t;
endpackage
`default_nettype wire

/* rtl/mps_if.sv */
// Valid/ready channel interface for input items and result items.
`default_nettype none
interface mps_if #(parameter int W = 1);
	logic         valid;
	logic         ready;
	logic [W-1:0] data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

/* rtl/mps_unit.sv */
// Shared bit-serial modular unit: product mod n, and Shoup quotient w*2^W/n.
`default_nettype none
module mps_unit
	import mps_pkg::*;
#(
	parameter int WORD_BITS = WORD_BITS_DEF
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire unit_ctl_t           ctl,
	input  wire logic [MOD_BITS-1:0] x,
	input  wire logic [MOD_BITS-1:0] y,
	input  wire logic [MOD_BITS-1:0] n,
	output logic                     done,
	output logic [MOD_BITS-1:0]      rem,
	output logic [WORD_BITS-1:0]     quo
);
	localparam int PB = 2 * MOD_BITS;
	localparam int CW = $clog2(PB + 1);

	// Multiplication is done with a 32x32 multiplier as four partial products, then the
	// 126-bit product is reduced one bit per cycle. The quotient shifts in zeros.
	logic            busy_q;
	logic            done_q;
	op_t             op_q;
	logic [2:0]      mph_q;
	logic            mulph_q;
	logic [PB-1:0]   prod_q;
	logic [CW-1:0]   cnt_q;
	logic [MOD_BITS-1:0] r_q;
	logic [WORD_BITS-1:0] q_q;
	logic [31:0]     xa, yb;
	logic [63:0]     pp;
	logic [MOD_BITS:0] r2;
	logic            ge;
	logic            inbit;

	assign pp = {32'd0, xa} * {32'd0, yb};
	always_comb begin
		xa = mph_q[0] ? {1'b0, x[MOD_BITS-1:32]} : x[31:0];
		yb = mph_q[1] ? {1'b0, y[MOD_BITS-1:32]} : y[31:0];
		inbit = (op_q == OP_MULMOD) ? prod_q[PB-1] : 1'b0;
		r2 = {r_q, inbit};
		ge = (r2 >= {1'b0, n});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			done_q  <= 1'b0;
			mulph_q <= 1'b0;
			mph_q   <= '0;
			op_q    <= OP_MULMOD;
			prod_q  <= '0;
			cnt_q   <= '0;
			r_q     <= '0;
			q_q     <= '0;
		end else begin
			done_q <= 1'b0;
			if (ctl.start) begin
				busy_q <= 1'b1;
				op_q   <= ctl.op;
				mph_q  <= '0;
				mulph_q <= (ctl.op == OP_MULMOD);
				prod_q <= '0;
				if (ctl.op == OP_MULMOD) begin
					r_q   <= '0;
					cnt_q <= CW'(PB);
				end else begin
					r_q   <= y;
					cnt_q <= CW'(WORD_BITS);
				end
				q_q <= '0;
			end else if (busy_q) begin
				if (mulph_q) begin
					prod_q <= prod_q + (PB'(pp) << (32 * (int'(mph_q[0]) + int'(mph_q[1]))));
					mph_q  <= mph_q + 3'd1;
					if (mph_q == 3'd3) mulph_q <= 1'b0;
				end else begin
					r_q    <= ge ? MOD_BITS'(r2 - {1'b0, n}) : r2[MOD_BITS-1:0];
					q_q    <= {q_q[WORD_BITS-2:0], ge};
					prod_q <= prod_q << 1;
					cnt_q  <= cnt_q - CW'(1);
					if (cnt_q == CW'(1)) begin
						busy_q <= 1'b0;
						done_q <= 1'b1;
					end
				end
			end
		end
	end
	assign done = done_q;
	assign rem = r_q;
	assign quo = q_q;
endmodule
`default_nettype wire

/* rtl/modular_power_sequence_shoup.sv */
// Top level: sequencer, state, configuration port and output register.
`default_nettype none
// Produces a^i mod n with Shoup quotients, one result per input transfer.
// A start item passes through a setup state (S_RED), then a quotient pass of
// WORD_BITS steps on the shared unit; a next item has four partial products on
// the multiplier, 126 reduction steps, then a quotient pass. Error items have
// their result valid in the cycle after their transfer. The single bit-serial
// modular unit does the multiply, reduction and quotient work. The input is not
// ready while an item is in work or a result waits in the output register.
module modular_power_sequence_shoup
	import mps_pkg::*;
#(
	parameter int WORD_BITS   = WORD_BITS_DEF,
	parameter int LENGTH_BITS = LENGTH_BITS_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [63:0] pwdata,
	output logic [63:0]      prdata,
	output logic             pready,
	mps_if.sink              in_ch,
	mps_if.source            out_ch
);
	localparam int OW = IDX_BITS + 2 * MOD_BITS + 2 * WORD_BITS + 1 + 2;

	logic [MOD_BITS-1:0] modulus_q, ratio_q, power_q, wval_q;
	logic [WORD_BITS-1:0] pquo_q;
	logic [LENGTH_BITS-1:0] next_q, total_q;
	logic [IDX_BITS-1:0] idx_q;
	logic running_q, last_q;
	state_t state_q, state_d;
	unit_ctl_t ctl;
	logic done;
	logic [MOD_BITS-1:0] urem;
	logic [WORD_BITS-1:0] uquo;
	logic [OW-1:0] out_q;
	logic out_v_q;

	logic in_act;
	logic [MOD_BITS-1:0] in_base;
	logic [LENGTH_BITS-1:0] in_len;
	logic acc;
	logic [LENGTH_BITS-1:0] next_inc;

	assign in_act  = in_ch.data[0];
	assign in_base = in_ch.data[MOD_BITS:1];
	assign in_len  = in_ch.data[MOD_BITS+LENGTH_BITS:MOD_BITS+1];
	assign in_ch.ready = (state_q == S_IDLE) && !out_v_q;
	assign acc = in_ch.valid && in_ch.ready;
	assign next_inc = next_q + LENGTH_BITS'(1);

	assign pready = 1'b1;
	assign prdata = (paddr == 3'd0) ? {1'b0, modulus_q} : 64'd0;

	mps_unit #(.WORD_BITS(WORD_BITS)) u_unit (
		.clk(clk), .arst_n(arst_n), .ctl(ctl),
		.x(ratio_q), .y(power_q), .n(modulus_q),
		.done(done), .rem(urem), .quo(uquo)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_IDLE;
		else state_q <= state_d;
	end

	// A start passes through S_RED so that the quotient pass sees the new power.
	always_comb begin
		state_d   = state_q;
		ctl.start = 1'b0;
		ctl.op    = OP_MULMOD;
		unique case (state_q)
			S_IDLE: begin
				if (acc && in_act == ACT_START && in_base < modulus_q && in_len != '0) begin
					state_d = S_RED;
				end else if (acc && in_act == ACT_NEXT && running_q && next_q < total_q) begin
					state_d = S_MUL;
					ctl.start = 1'b1;
				end
			end
			S_MUL: if (done) begin
				state_d = S_RED;
			end
			S_RED: begin
				state_d = S_QUO;
				ctl.start = 1'b1;
				ctl.op = OP_QUO;
			end
			S_QUO: if (done) begin
				state_d = S_OUT;
			end
			S_OUT: state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	// The quotient pass reads its dividend from the y operand's register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			modulus_q <= MOD_BITS'(2);
			ratio_q   <= '0;
			power_q   <= '0;
			pquo_q    <= '0;
			next_q    <= '0;
			total_q   <= '0;
			running_q <= 1'b0;
			out_v_q   <= 1'b0;
			out_q     <= '0;
			last_q    <= 1'b0;
			idx_q     <= '0;
			wval_q    <= '0;
		end else begin
			if (psel && penable && pwrite && paddr == 3'd0)
				modulus_q <= (pwdata[MOD_BITS-1:0] < MOD_BITS'(2)) ? MOD_BITS'(2)
					: pwdata[MOD_BITS-1:0];
			if (out_ch.valid && out_ch.ready) out_v_q <= 1'b0;
			unique case (state_q)
				S_IDLE: if (acc) begin
					if (in_act == ACT_START) begin
						if (in_base >= modulus_q) begin
							running_q <= 1'b0;
							out_q <= {{(OW-2){1'b0}}, ST_BAD_BASE};
							out_v_q <= 1'b1;
						end else if (in_len == '0) begin
							running_q <= 1'b0;
							out_q <= {{(OW-2){1'b0}}, ST_PAST_END};
							out_v_q <= 1'b1;
						end else begin
							ratio_q <= in_base;
							power_q <= MOD_BITS'(1);
							total_q <= in_len;
							next_q  <= LENGTH_BITS'(1);
							last_q  <= (in_len == LENGTH_BITS'(1));
							running_q <= (in_len != LENGTH_BITS'(1));
							idx_q   <= '0;
						end
					end else if (running_q && next_q < total_q) begin
						last_q  <= (next_inc == total_q);
						idx_q   <= IDX_BITS'(next_q);
						next_q  <= next_inc;
						if (next_inc == total_q) running_q <= 1'b0;
					end else begin
						out_q <= {{(OW-2){1'b0}}, ST_PAST_END};
						out_v_q <= 1'b1;
					end
				end
				S_MUL: if (done) power_q <= urem;
				S_QUO: if (done) begin
					pquo_q <= uquo;
					wval_q <= power_q;
				end
				S_OUT: begin
					out_q <= {idx_q, wval_q, pquo_q, MOD_BITS'(modulus_q - wval_q),
						~pquo_q, last_q, ST_OK};
					out_v_q <= 1'b1;
				end
				default: ;
			endcase
		end
	end

	assign out_ch.valid = out_v_q;
	assign out_ch.data  = out_q;
endmodule
`default_nettype wire

/* bench/tb.sv */
// Testbench for the modular power sequence block with its directed table and random phases.
`timescale 1ns / 100ps
module tb;
	import mps_pkg::*;

	localparam int LIMIT = 1500000;
	localparam int DRAIN = 300;
	localparam logic [62:0] M63 = {63{1'b1}};

	typedef struct packed {
		logic [31:0] idx;
		logic [62:0] pw;
		logic [63:0] pq;
		logic [62:0] ov;
		logic [63:0] oq;
		logic        last;
		status_t     st;
	} elem_t;

	typedef enum logic {ROW_ITEM, ROW_MOD} row_kind_t;

	typedef struct {
		row_kind_t   kind;
		action_t     act;
		logic [62:0] base;
		logic [31:0] len;
		bit          typed;
		elem_t       res;
	} row_t;

	logic clk;
	logic arst_n;
	logic psel, penable, pwrite;
	logic [2:0] paddr;
	logic [63:0] pwdata;
	logic [63:0] prdata;
	logic pready;

	mps_if #(.W(96)) in_ch ();
	mps_if #(.W(289)) out_ch ();

	modular_power_sequence_shoup uut (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.in_ch(in_ch), .out_ch(out_ch)
	);

	// Predictor state.
	logic [62:0] mod_n;
	logic [62:0] seq_ratio;
	logic [62:0] seq_power;
	logic [63:0] seq_quo;
	logic [31:0] seq_next;
	logic [31:0] seq_len;
	bit          seq_active;

	elem_t expected_q[$];
	row_t  rows[$];
	int    errors;
	int    cycles;
	int    sent;
	bit    calm;

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT) begin
			$display("FAIL modular_power_sequence_shoup");
			$finish;
		end
	end

	function automatic logic [63:0] shoup_of(logic [62:0] w, logic [62:0] n);
		logic [127:0] num;
		num = {64'd0, 64'(w % n)} << 64;
		return 64'(num / {65'd0, n});
	endfunction

	function automatic elem_t error_elem(status_t s);
		elem_t e;
		e = '0;
		e.st = s;
		return e;
	endfunction

	function automatic elem_t emit_power(logic [31:0] i, bit last);
		elem_t e;
		e.idx = i;
		e.pw = seq_power;
		e.pq = seq_quo;
		e.ov = mod_n - seq_power;
		e.oq = ~seq_quo;
		e.last = last;
		e.st = ST_OK;
		return e;
	endfunction

	function automatic elem_t next_power(action_t act, logic [62:0] a, logic [31:0] d);
		logic [127:0] prod;
		bit last;
		logic [31:0] i;
		if (act == ACT_START) begin
			if (a >= mod_n) begin
				seq_active = 0;
				return error_elem(ST_BAD_BASE);
			end
			if (d == 0) begin
				seq_active = 0;
				return error_elem(ST_PAST_END);
			end
			seq_ratio = a;
			seq_power = 63'd1;
			seq_quo = shoup_of(63'd1, mod_n);
			seq_len = d;
			seq_next = 32'd1;
			last = (d == 1);
			seq_active = !last;
			return emit_power(32'd0, last);
		end
		if (!seq_active || seq_next >= seq_len)
			return error_elem(ST_PAST_END);
		prod = {65'd0, seq_ratio} * {65'd0, seq_power};
		seq_power = 63'(prod % {65'd0, mod_n});
		seq_quo = shoup_of(seq_power, mod_n);
		last = (seq_next + 1 == seq_len);
		i = seq_next;
		seq_next = seq_next + 1;
		if (last) seq_active = 0;
		return emit_power(i, last);
	endfunction

	task automatic send_item(action_t act, logic [62:0] a, logic [31:0] d, bit typed,
			elem_t typed_res);
		int gap;
		elem_t p;
		@(negedge clk);
		if (!calm && $urandom_range(0, 4) == 0) begin
			gap = $urandom_range(1, 9);
			in_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.data <= {d, a, act};
		do @(posedge clk); while (!in_ch.ready);
		p = next_power(act, a, d);
		expected_q.push_back(typed ? typed_res : p);
		sent++;
	endtask

	// Drops valid and waits until every result is back and the block is quiet.
	task automatic settle();
		@(negedge clk);
		in_ch.valid <= 1'b0;
		wait (expected_q.size() == 0);
		repeat (DRAIN) @(posedge clk);
	endtask

	task automatic write_modulus(logic [62:0] v);
		settle();
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= 3'd0;
		pwdata <= {1'b0, v};
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		mod_n = (v < 2) ? 63'd2 : v;
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic add_row(row_kind_t k, action_t act, logic [62:0] a, logic [31:0] d,
			bit typed, elem_t r);
		row_t row;
		row.kind = k;
		row.act = act;
		row.base = a;
		row.len = d;
		row.typed = typed;
		row.res = r;
		rows.push_back(row);
	endtask

	task automatic check_field(string name, logic [63:0] e, logic [63:0] a);
		if (e !== a) begin
			$display("%0t: %s mismatch, expected %h, got %h", $time, name, e, a);
			errors++;
		end
	endtask

	// Output side: random stall bursts, then the result check on each transfer.
	initial begin
		int stall;
		stall = 0;
		out_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (stall > 0) begin
				stall--;
			end else if (!calm && $urandom_range(0, 5) == 0) begin
				stall = $urandom_range(1, 9);
				out_ch.ready <= 1'b0;
			end else begin
				out_ch.ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		elem_t got, want;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			got = elem_t'(out_ch.data);
			if (expected_q.size() == 0) begin
				$display("%0t: unexpected result, expected none, got %h", $time, got);
				errors++;
			end else begin
				want = expected_q.pop_front();
				check_field("element_index", 64'(want.idx), 64'(got.idx));
				check_field("power_value", 64'(want.pw), 64'(got.pw));
				check_field("power_quotient", want.pq, got.pq);
				check_field("opposite_value", 64'(want.ov), 64'(got.ov));
				check_field("opposite_quotient", want.oq, got.oq);
				check_field("last_flag", 64'(want.last), 64'(got.last));
				check_field("status", 64'(want.st), 64'(got.st));
			end
		end
	end

	task automatic random_phase(logic [62:0] m, int quota);
		int target, n, k;
		logic [62:0] a;
		logic [31:0] d;
		write_modulus(m);
		target = sent + quota;
		while (sent < target) begin
			a = {$urandom, $urandom} & M63;
			k = $urandom_range(0, 19);
			if (k == 0) begin
				send_item(ACT_START, a, 32'd0, 0, '0);
			end else if (k == 1) begin
				send_item(ACT_START, a, $urandom, 0, '0);
			end else if (k == 2) begin
				send_item(ACT_NEXT, a, $urandom, 0, '0);
			end else begin
				// Well-formed sequence with random content, sometimes overrun.
				d = (k == 3) ? $urandom : $urandom_range(1, 7);
				send_item(ACT_START, a % mod_n, d, 0, '0);
				n = (d > 8) ? $urandom_range(1, 6) : d - 1 + ($urandom_range(0, 3) == 0);
				repeat (n) send_item(ACT_NEXT, {$urandom, $urandom} & M63, $urandom, 0, '0);
			end
		end
	endtask

	initial begin
		elem_t r;
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		in_ch.valid = 1'b0;
		in_ch.data = '0;
		errors = 0;
		cycles = 0;
		sent = 0;
		calm = 0;
		mod_n = 63'd2;
		seq_ratio = '0;
		seq_power = '0;
		seq_quo = '0;
		seq_next = '0;
		seq_len = '0;
		seq_active = 0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Modulus 2 after reset: a one-element sequence is 1 with quotient 2^63.
		r = '{32'd0, 63'd1, 64'h8000_0000_0000_0000, 63'd1, 64'h7FFF_FFFF_FFFF_FFFF,
			1'b1, ST_OK};
		add_row(ROW_ITEM, ACT_START, 63'd0, 32'd1, 1, r);
		add_row(ROW_ITEM, ACT_NEXT, M63, 32'hFFFF_FFFF, 1, error_elem(ST_PAST_END));
		add_row(ROW_ITEM, ACT_START, 63'd2, 32'd3, 1, error_elem(ST_BAD_BASE));
		add_row(ROW_ITEM, ACT_START, 63'd1, 32'd0, 1, error_elem(ST_PAST_END));
		add_row(ROW_MOD, ACT_START, 63'd0, 32'd0, 0, '0);
		add_row(ROW_ITEM, ACT_START, 63'd1, 32'd2, 0, '0);
		add_row(ROW_ITEM, ACT_NEXT, 63'd0, 32'd0, 0, '0);
		add_row(ROW_MOD, ACT_START, M63, 32'd0, 0, '0);
		add_row(ROW_ITEM, ACT_START, M63 - 1, 32'd4, 0, '0);
		repeat (3) add_row(ROW_ITEM, ACT_NEXT, 63'd0, 32'd0, 0, '0);
		add_row(ROW_ITEM, ACT_NEXT, 63'd0, 32'd0, 1, error_elem(ST_PAST_END));
		add_row(ROW_ITEM, ACT_START, M63, 32'd2, 1, error_elem(ST_BAD_BASE));
		add_row(ROW_MOD, ACT_START, 63'd1000003, 32'd0, 0, '0);
		// Zero ratio gives a zero power, whose opposite is the modulus itself.
		add_row(ROW_ITEM, ACT_START, 63'd0, 32'hFFFF_FFFF, 0, '0);
		add_row(ROW_ITEM, ACT_NEXT, 63'd0, 32'd0, 0, '0);
		add_row(ROW_ITEM, ACT_START, 63'd999999, 32'd6, 0, '0);
		add_row(ROW_ITEM, ACT_NEXT, 63'd0, 32'd0, 0, '0);
		// The modulus changes in the middle of a sequence.
		add_row(ROW_MOD, ACT_START, 63'd97, 32'd0, 0, '0);
		add_row(ROW_ITEM, ACT_NEXT, 63'd0, 32'd0, 0, '0);
		add_row(ROW_ITEM, ACT_NEXT, 63'd0, 32'd0, 0, '0);
		add_row(ROW_MOD, ACT_START, 63'd1, 32'd0, 0, '0);
		add_row(ROW_ITEM, ACT_START, 63'd1, 32'd3, 0, '0);
		add_row(ROW_ITEM, ACT_START, 63'd0, 32'd1, 0, '0);
		add_row(ROW_ITEM, ACT_NEXT, 63'd0, 32'd0, 1, error_elem(ST_PAST_END));

		foreach (rows[i]) begin
			if (rows[i].kind == ROW_MOD)
				write_modulus(rows[i].base);
			else
				send_item(rows[i].act, rows[i].base, rows[i].len, rows[i].typed,
					rows[i].res);
		end

		random_phase(({$urandom, $urandom} & M63) | 63'd2, 110);
		random_phase(M63, 110);
		random_phase(63'($urandom_range(3, 200)), 100);
		random_phase(63'h4000_0000_0000_0001 + 63'($urandom), 90);
		calm = 1;
		random_phase(63'($urandom) | 63'd2, 90);

		settle();
		if (errors == 0)
			$display("PASS modular_power_sequence_shoup");
		else
			$display("FAIL modular_power_sequence_shoup");
		$finish;
	end
endmodule

/* modular_power_sequence_shoup.f */
rtl/mps_pkg.sv
rtl/mps_if.sv
rtl/mps_unit.sv
rtl/modular_power_sequence_shoup.sv
bench/tb.sv
